// ===== rtl/fscs_pkg.sv =====
// Shared types and constants for the FPGA serial configuration sequencer.
// No dependencies; every other file of the block imports this package.
package fscs_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_PROG_HIGH_TICKS   = 3'd0;
    localparam logic [2:0] REG_PROG_LOW_TICKS    = 3'd1;
    localparam logic [2:0] REG_INIT_LOW_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_INIT_HIGH_TIMEOUT = 3'd3;
    localparam logic [2:0] REG_TRAILER_CLOCKS    = 3'd4;

    // Register reset values
    localparam logic [7:0]  PROG_HIGH_TICKS_RST   = 8'd10;
    localparam logic [7:0]  PROG_LOW_TICKS_RST    = 8'd5;
    localparam logic [11:0] INIT_LOW_TIMEOUT_RST  = 12'd200;
    localparam logic [11:0] INIT_HIGH_TIMEOUT_RST = 12'd256;
    localparam logic [11:0] TRAILER_CLOCKS_RST    = 12'd50;

    // Bits per bitstream byte
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // Stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // Completion codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INIT_LOW  = 2'd1,
        ST_INIT_HIGH = 2'd2,
        ST_DONE_LOW  = 2'd3
    } status_t;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_HIGH      = 4'd1,
        PH_LOW1      = 4'd2,
        PH_WAITLOW   = 4'd3,
        PH_LOW2      = 4'd4,
        PH_WAITHIGH  = 4'd5,
        PH_DATA      = 4'd6,
        PH_TRAILER   = 4'd7
    } phase_t;

    // One tick as it arrives
    typedef struct packed {
        logic       start_req;
        logic       init_level;
        logic       done_level;
        logic       byte_valid;
        logic [7:0] bitstream_byte;
        logic       last_byte;
    } tick_in_t;

    // One tick's report
    typedef struct packed {
        logic    prog_level;
        logic    data_bit;
        logic    clock_rise;
        logic    byte_ready;
        logic    busy_res;
        status_t status;
        logic    status_valid;
    } tick_out_t;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  prog_high_ticks;
        logic [7:0]  prog_low_ticks;
        logic [11:0] init_low_timeout;
        logic [11:0] init_high_timeout;
        logic [11:0] trailer_clocks;
    } cfg_t;

endpackage

// ===== rtl/fpga_serial_config_sequencer.sv =====
// Channel   | Direction | Beat carries
// s_axis    | in        | one tick: start, init/done pins, optional byte, last mark
// m_axis    | out       | one report per tick: pin levels, byte ready, busy, status
// cfg       | in        | register write: index and data, taken when cfg_we is high
//
// Each tick passes an input register, the next-state logic and an output
// register; one tick is accepted per cycle while neither side stalls.
// The state machine advances only when a tick moves into the output register,
// so stalls on either side hold all state. aresetn is synchronous, active low,
// and restores the register defaults. Top level; depends on fscs_pkg and the
// fscs_cfg_regs, fscs_in_stage, fscs_engine and fscs_out_stage modules.
module fpga_serial_config_sequencer
    import fscs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Slave side
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // start_req[0], init_level[1], done_level[2], byte_valid[3],
    // bitstream_byte[11:4], zero fill[15:12]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    // Master side
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // prog_level[0], data_bit[1], clock_rise[2], byte_ready[3], busy_res[4],
    // status[6:5], status_valid[7]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [11:0]            cfg_wdata
);

    cfg_t      cfg;
    tick_in_t  in_item;
    tick_in_t  held_item;
    logic      held_valid;
    logic      step_en;
    logic      out_room;
    tick_out_t step_result;
    tick_out_t out_item;

    // Unpack the incoming beat
    assign in_item.start_req      = s_tdata[0];
    assign in_item.init_level     = s_tdata[1];
    assign in_item.done_level     = s_tdata[2];
    assign in_item.byte_valid     = s_tdata[3];
    assign in_item.bitstream_byte = s_tdata[11:4];
    assign in_item.last_byte      = s_tlast;

    fscs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fscs_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (held_valid),
        .item_take  (step_en),
        .item       (held_item)
    );

    // Advance one tick when an input is held and the result has room
    assign step_en = held_valid && out_room;

    fscs_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (held_item),
        .cfg     (cfg),
        .result  (step_result)
    );

    fscs_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step_en),
        .load_item (step_result),
        .can_load  (out_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // Pack the report beat
    assign m_tdata = {out_item.status_valid, out_item.status, out_item.busy_res,
                      out_item.byte_ready, out_item.clock_rise, out_item.data_bit,
                      out_item.prog_level};

`ifndef NO_ASSERTIONS
    // A finishing tick never reports the sequence as still running
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[7]) |-> !m_tdata[4])
        else $error("status_valid with busy set");

    // A nonzero status appears only on a finishing tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[6:5] != ST_OK) |-> m_tdata[7])
        else $error("status code without status_valid");

    // Clock pulses are only issued inside a running sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> m_tdata[4])
        else $error("clock_rise while idle");

    // A stalled report holds its contents
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled report changed");
`endif

endmodule

// ===== rtl/fscs_cfg_regs.sv =====
// Configuration register file of the sequencer: five write-only registers.
// Depends on fscs_pkg for register indexes, reset values and cfg_t.
module fscs_cfg_regs
    import fscs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    // Write the addressed register; other indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prog_high_ticks   <= PROG_HIGH_TICKS_RST;
            cfg_reg.prog_low_ticks    <= PROG_LOW_TICKS_RST;
            cfg_reg.init_low_timeout  <= INIT_LOW_TIMEOUT_RST;
            cfg_reg.init_high_timeout <= INIT_HIGH_TIMEOUT_RST;
            cfg_reg.trailer_clocks    <= TRAILER_CLOCKS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PROG_HIGH_TICKS:   cfg_reg.prog_high_ticks   <= cfg_wdata[7:0];
                REG_PROG_LOW_TICKS:    cfg_reg.prog_low_ticks    <= cfg_wdata[7:0];
                REG_INIT_LOW_TIMEOUT:  cfg_reg.init_low_timeout  <= cfg_wdata;
                REG_INIT_HIGH_TIMEOUT: cfg_reg.init_high_timeout <= cfg_wdata;
                REG_TRAILER_CLOCKS:    cfg_reg.trailer_clocks    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/fscs_in_stage.sv =====
// Input register of the sequencer: holds one tick until the engine takes it.
// Depends on fscs_pkg for tick_in_t.
module fscs_in_stage
    import fscs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  tick_in_t in_item,
    output logic     item_valid,
    input  logic     item_take,
    output tick_in_t item
);

    logic     valid_reg;
    tick_in_t item_reg;

    // Accept a new beat when empty or when the held one leaves this cycle
    assign in_ready = !valid_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/fscs_engine.sv =====
// Sequencer state machine: advances the pin sequence, counters and shifter
// by one tick per step and forms that tick's report. Depends on fscs_pkg.
module fscs_engine
    import fscs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  tick_in_t  item,
    input  cfg_t      cfg,
    output tick_out_t result
);

    phase_t      phase_reg, phase_next;
    logic [11:0] tick_reg, tick_next;
    logic [7:0]  shift_reg, shift_next;
    logic [3:0]  bits_reg, bits_next;
    logic        final_reg, final_next;
    logic        prog_reg, prog_next;
    logic        data_reg, data_next;

    logic [11:0] tick_inc;
    logic [12:0] tick_inc_plus;
    logic        clk_rise;
    logic        ready;
    status_t     status;
    logic        svalid;

    assign tick_inc      = tick_reg + 12'd1;
    assign tick_inc_plus = {1'b0, tick_inc} + 13'd1;

    // State registers, updated once per consumed tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            shift_reg <= '0;
            bits_reg  <= '0;
            final_reg <= 1'b0;
            prog_reg  <= 1'b1;
            data_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            final_reg <= final_next;
            prog_reg  <= prog_next;
            data_reg  <= data_next;
        end
    end

    // Next state and this tick's report
    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        final_next = final_reg;
        prog_next  = prog_reg;
        data_next  = data_reg;
        clk_rise   = 1'b0;
        ready      = 1'b0;
        status     = ST_OK;
        svalid     = 1'b0;

        case (phase_reg)
            PH_HIGH: begin
                tick_next = tick_inc;
                if (tick_inc_plus >= {5'd0, cfg.prog_high_ticks}) begin
                    phase_next = PH_LOW1;
                    tick_next  = '0;
                    prog_next  = 1'b0;
                end
            end
            PH_LOW1: begin
                tick_next = tick_inc;
                if (tick_inc >= {4'd0, cfg.prog_low_ticks}) begin
                    phase_next = PH_WAITLOW;
                    tick_next  = '0;
                end
            end
            PH_WAITLOW: begin
                if (!item.init_level) begin
                    phase_next = PH_LOW2;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_inc;
                    if (tick_inc >= cfg.init_low_timeout) begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                        prog_next  = 1'b1;
                        status     = ST_INIT_LOW;
                        svalid     = 1'b1;
                    end
                end
            end
            PH_LOW2: begin
                tick_next = tick_inc;
                if (tick_inc >= {4'd0, cfg.prog_low_ticks}) begin
                    phase_next = PH_WAITHIGH;
                    tick_next  = '0;
                    prog_next  = 1'b1;
                end
            end
            PH_WAITHIGH: begin
                if (item.init_level) begin
                    phase_next = PH_DATA;
                    tick_next  = '0;
                    bits_next  = '0;
                    final_next = 1'b0;
                end else begin
                    tick_next = tick_inc;
                    if (tick_inc >= cfg.init_high_timeout) begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                        status     = ST_INIT_HIGH;
                        svalid     = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                if (bits_reg == '0) begin
                    // Take a byte and send its msb on the same tick
                    ready = 1'b1;
                    if (item.byte_valid) begin
                        data_next  = item.bitstream_byte[7];
                        shift_next = {item.bitstream_byte[6:0], 1'b0};
                        bits_next  = BYTE_BITS - 4'd1;
                        final_next = item.last_byte;
                        clk_rise   = 1'b1;
                    end
                end else begin
                    data_next  = shift_reg[7];
                    shift_next = {shift_reg[6:0], 1'b0};
                    bits_next  = bits_reg - 4'd1;
                    clk_rise   = 1'b1;
                end
                if (clk_rise && bits_next == '0 && final_next) begin
                    phase_next = PH_TRAILER;
                    tick_next  = '0;
                end
            end
            PH_TRAILER: begin
                if (tick_reg < cfg.trailer_clocks) begin
                    tick_next = tick_inc;
                    clk_rise  = 1'b1;
                end else begin
                    // Trailer finished: check done
                    data_next  = 1'b1;
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    status     = item.done_level ? ST_OK : ST_DONE_LOW;
                    svalid     = 1'b1;
                end
            end
            default: begin
                // Idle and unused codes
                phase_next = PH_IDLE;
                if (item.start_req) begin
                    phase_next = PH_HIGH;
                    tick_next  = '0;
                    prog_next  = 1'b1;
                    data_next  = 1'b0;
                    bits_next  = '0;
                    final_next = 1'b0;
                    shift_next = '0;
                    if (cfg.prog_high_ticks <= 8'd1) begin
                        phase_next = PH_LOW1;
                        prog_next  = 1'b0;
                    end
                end
            end
        endcase
    end

    assign result.prog_level   = prog_next;
    assign result.data_bit     = data_next;
    assign result.clock_rise   = clk_rise;
    assign result.byte_ready   = ready;
    assign result.busy_res     = (phase_next != PH_IDLE);
    assign result.status       = status;
    assign result.status_valid = svalid;

endmodule

// ===== rtl/fscs_out_stage.sv =====
// Result register of the sequencer: holds one report until the sink takes it.
// Depends on fscs_pkg for tick_out_t.
module fscs_out_stage
    import fscs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  tick_out_t load_item,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_ready,
    output tick_out_t out_item
);

    logic      valid_reg;
    tick_out_t item_reg;

    // Room when empty or when the held beat is taken this cycle
    assign can_load = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= load_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the FPGA serial configuration sequencer:
// a queue-fed tick driver, a report monitor and a tick-level predictor.
// Depends on fscs_pkg and fpga_serial_config_sequencer from rtl.
module testbench;
    import fscs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // Predicted sequencer state
    typedef struct packed {
        phase_t      phase;
        logic [11:0] ticks;
        logic [7:0]  shreg;
        logic [3:0]  bits_left;
        logic        final_seen;
        logic        prog_line;
        logic        data_line;
    } seq_state_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [2:0]             cfg_index = REG_PROG_HIGH_TICKS;
    logic [11:0]            cfg_wdata = '0;

    tick_in_t   pending_ticks[$];
    tick_out_t  expected_reports[$];
    tick_in_t   in_flight;
    tick_out_t  predicted;
    tick_out_t  want_rpt;
    seq_state_t chk_state;
    seq_state_t chk_next;
    seq_state_t gen_state;
    cfg_t       cfg_shadow;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         mismatches = 0;
    int         cycle_count = 0;
    logic       plan_low_timeout = 1'b0;
    logic       plan_high_timeout = 1'b0;
    int         bytes_to_go = 0;

    fpga_serial_config_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Advance the sequencer by one tick and form that tick's report
    function automatic void sequencer_step(input seq_state_t cur, input cfg_t c,
                                           input tick_in_t t, output seq_state_t nxt,
                                           output tick_out_t rpt);
        logic clk_rise;
        logic ready;
        nxt = cur;
        rpt = '0;
        clk_rise = 1'b0;
        ready = 1'b0;
        rpt.status = ST_OK;
        rpt.status_valid = 1'b0;
        case (cur.phase)
            PH_HIGH: begin
                nxt.ticks = cur.ticks + 12'd1;
                if ({1'b0, nxt.ticks} + 13'd1 >= {5'd0, c.prog_high_ticks}) begin
                    nxt.phase = PH_LOW1;
                    nxt.ticks = '0;
                    nxt.prog_line = 1'b0;
                end
            end
            PH_LOW1: begin
                nxt.ticks = cur.ticks + 12'd1;
                if (nxt.ticks >= {4'd0, c.prog_low_ticks}) begin
                    nxt.phase = PH_WAITLOW;
                    nxt.ticks = '0;
                end
            end
            PH_WAITLOW: begin
                if (!t.init_level) begin
                    nxt.phase = PH_LOW2;
                    nxt.ticks = '0;
                end else begin
                    nxt.ticks = cur.ticks + 12'd1;
                    // give up and release program
                    if (nxt.ticks >= c.init_low_timeout) begin
                        nxt.phase = PH_IDLE;
                        nxt.ticks = '0;
                        nxt.prog_line = 1'b1;
                        rpt.status = ST_INIT_LOW;
                        rpt.status_valid = 1'b1;
                    end
                end
            end
            PH_LOW2: begin
                nxt.ticks = cur.ticks + 12'd1;
                if (nxt.ticks >= {4'd0, c.prog_low_ticks}) begin
                    nxt.phase = PH_WAITHIGH;
                    nxt.ticks = '0;
                    nxt.prog_line = 1'b1;
                end
            end
            PH_WAITHIGH: begin
                if (t.init_level) begin
                    nxt.phase = PH_DATA;
                    nxt.ticks = '0;
                    nxt.bits_left = '0;
                    nxt.final_seen = 1'b0;
                end else begin
                    nxt.ticks = cur.ticks + 12'd1;
                    if (nxt.ticks >= c.init_high_timeout) begin
                        nxt.phase = PH_IDLE;
                        nxt.ticks = '0;
                        rpt.status = ST_INIT_HIGH;
                        rpt.status_valid = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                // load a new byte only when the shifter is empty
                if (cur.bits_left == 4'd0) begin
                    ready = 1'b1;
                    if (t.byte_valid) begin
                        nxt.shreg = t.bitstream_byte;
                        nxt.bits_left = BYTE_BITS;
                        nxt.final_seen = t.last_byte;
                        clk_rise = 1'b1;
                    end
                end else begin
                    clk_rise = 1'b1;
                end
                // shift msb first, one bit per clock rise
                if (clk_rise) begin
                    nxt.data_line = nxt.shreg[7];
                    nxt.shreg = nxt.shreg << 1;
                    nxt.bits_left = nxt.bits_left - 4'd1;
                    if (nxt.bits_left == 4'd0 && nxt.final_seen) begin
                        nxt.phase = PH_TRAILER;
                        nxt.ticks = '0;
                    end
                end
            end
            PH_TRAILER: begin
                if (cur.ticks < c.trailer_clocks) begin
                    nxt.ticks = cur.ticks + 12'd1;
                    clk_rise = 1'b1;
                end else begin
                    nxt.data_line = 1'b1;
                    nxt.phase = PH_IDLE;
                    nxt.ticks = '0;
                    rpt.status = t.done_level ? ST_OK : ST_DONE_LOW;
                    rpt.status_valid = 1'b1;
                end
            end
            default: begin
                nxt.phase = PH_IDLE;
                if (t.start_req) begin
                    nxt.phase = PH_HIGH;
                    nxt.ticks = '0;
                    nxt.prog_line = 1'b1;
                    nxt.data_line = 1'b0;
                    nxt.bits_left = '0;
                    nxt.final_seen = 1'b0;
                    nxt.shreg = '0;
                    if (c.prog_high_ticks <= 8'd1) begin
                        nxt.phase = PH_LOW1;
                        nxt.prog_line = 1'b0;
                    end
                end
            end
        endcase
        rpt.prog_level = nxt.prog_line;
        rpt.data_bit   = nxt.data_line;
        rpt.clock_rise = clk_rise;
        rpt.byte_ready = ready;
        rpt.busy_res   = (nxt.phase != PH_IDLE);
    endfunction

    // Queue one tick and track where the sequencer will be after it
    task automatic queue_tick(input logic st, input logic ini, input logic dn,
                              input logic bv, input logic [7:0] b, input logic lst);
        tick_in_t   t;
        seq_state_t nxt;
        tick_out_t  unused_rpt;
        t.start_req = st;
        t.init_level = ini;
        t.done_level = dn;
        t.byte_valid = bv;
        t.bitstream_byte = b;
        t.last_byte = lst;
        sequencer_step(gen_state, cfg_shadow, t, nxt, unused_rpt);
        gen_state = nxt;
        pending_ticks.push_back(t);
    endtask

    // Mostly well-formed sequences with random content, some pure noise
    task automatic queue_random_ticks(input int n);
        logic       st;
        logic       ini;
        logic       dn;
        logic       bv;
        logic       lst;
        logic [7:0] b;
        repeat (n) begin
            st  = ($urandom_range(0, 3) == 0);
            ini = ($urandom_range(0, 1) == 1);
            dn  = ($urandom_range(0, 1) == 1);
            bv  = ($urandom_range(0, 1) == 1);
            lst = ($urandom_range(0, 1) == 1);
            b   = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 19) != 0) begin
                case (gen_state.phase)
                    PH_IDLE:     st = ($urandom_range(0, 9) != 0);
                    PH_WAITLOW:  ini = plan_low_timeout ? 1'b1 : ($urandom_range(0, 1) == 1);
                    PH_WAITHIGH: ini = plan_high_timeout ? 1'b0 : ($urandom_range(0, 1) == 1);
                    PH_DATA: begin
                        if (gen_state.bits_left == 4'd0) begin
                            bv  = ($urandom_range(0, 4) != 0);
                            lst = (bytes_to_go <= 1);
                        end
                    end
                    PH_TRAILER:  dn = ($urandom_range(0, 3) != 0);
                    default: ;
                endcase
            end
            // plan a fresh sequence; timeouts only where they stay short
            if (gen_state.phase == PH_IDLE && st) begin
                plan_low_timeout  = ($urandom_range(0, 7) == 0) &&
                                    (cfg_shadow.init_low_timeout <= 12'd64);
                plan_high_timeout = ($urandom_range(0, 7) == 0) &&
                                    (cfg_shadow.init_high_timeout <= 12'd64);
                bytes_to_go = $urandom_range(1, 4);
            end
            if (gen_state.phase == PH_DATA && gen_state.bits_left == 4'd0 && bv &&
                bytes_to_go > 0)
                bytes_to_go--;
            queue_tick(st, ini, dn, bv, b, lst);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_PROG_HIGH_TICKS:   cfg_shadow.prog_high_ticks = val[7:0];
            REG_PROG_LOW_TICKS:    cfg_shadow.prog_low_ticks = val[7:0];
            REG_INIT_LOW_TIMEOUT:  cfg_shadow.init_low_timeout = val;
            REG_INIT_HIGH_TIMEOUT: cfg_shadow.init_high_timeout = val;
            REG_TRAILER_CLOCKS:    cfg_shadow.trailer_clocks = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] ph, input logic [7:0] pl,
                                  input logic [11:0] ilt, input logic [11:0] iht,
                                  input logic [11:0] tc);
        write_reg(REG_PROG_HIGH_TICKS, {4'd0, ph});
        write_reg(REG_PROG_LOW_TICKS, {4'd0, pl});
        write_reg(REG_INIT_LOW_TIMEOUT, ilt);
        write_reg(REG_INIT_HIGH_TIMEOUT, iht);
        write_reg(REG_TRAILER_CLOCKS, tc);
    endtask

    // Wait until every tick is sent and reported, then let the pipeline settle
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [1:0] want,
                               input logic [1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Drive ticks from the queue; predict each beat as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            chk_state = '0;
            chk_state.prog_line = 1'b1;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                sequencer_step(chk_state, cfg_shadow, in_flight, chk_next, predicted);
                chk_state = chk_next;
                expected_reports.push_back(predicted);
            end
            if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_flight = pending_ticks.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'd0, in_flight.bitstream_byte, in_flight.byte_valid,
                             in_flight.done_level, in_flight.init_level,
                             in_flight.start_req};
                s_tlast  <= in_flight.last_byte;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the report side at random
    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Compare each report beat with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("report beat with no tick pending: tdata %0h", m_tdata);
                mismatches++;
            end else begin
                want_rpt = expected_reports.pop_front();
                check_field("prog_level", want_rpt.prog_level, m_tdata[0]);
                check_field("data_bit", want_rpt.data_bit, m_tdata[1]);
                check_field("clock_rise", want_rpt.clock_rise, m_tdata[2]);
                check_field("byte_ready", want_rpt.byte_ready, m_tdata[3]);
                check_field("busy_res", want_rpt.busy_res, m_tdata[4]);
                check_field("status", want_rpt.status, m_tdata[6:5]);
                check_field("status_valid", want_rpt.status_valid, m_tdata[7]);
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[fpga_serial_config_sequencer] ERROR");
            $finish;
        end
    end

    initial begin
        cfg_shadow.prog_high_ticks   = PROG_HIGH_TICKS_RST;
        cfg_shadow.prog_low_ticks    = PROG_LOW_TICKS_RST;
        cfg_shadow.init_low_timeout  = INIT_LOW_TIMEOUT_RST;
        cfg_shadow.init_high_timeout = INIT_HIGH_TIMEOUT_RST;
        cfg_shadow.trailer_clocks    = TRAILER_CLOCKS_RST;
        gen_state = '0;
        gen_state.prog_line = 1'b1;
        send_idle_pct = 8;
        recv_idle_pct = 69;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero high time, one full sequence, 0xFF then 0x00 as last byte,
        // start while busy, bytes offered while shifting, done low at the end
        apply_settings(8'd0, 8'd1, 12'd2, 12'd1, 12'd1);
        queue_tick(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        queue_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        queue_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b1);
        queue_tick(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b0);
        repeat (7) queue_tick(1'b1, 1'b0, 1'b1, 1'b1, 8'h5A, 1'b1);
        queue_tick(1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1);
        repeat (7) queue_tick(1'b0, 1'b1, 1'b0, 1'b0, 8'hA5, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        queue_tick(1'b0, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b1);
        wait_drained();

        // Random phases under a range of settings and idle patterns
        for (int b = 0; b < 9; b++) begin
            if (b < 3) begin
                send_idle_pct = 8;
                recv_idle_pct = 69;
            end else if (b < 6) begin
                send_idle_pct = 69;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (b)
                0: apply_settings(8'd1, 8'd1, 12'd1, 12'd1, 12'd0);
                1: apply_settings(8'd3, 8'd2, 12'd6, 12'd5, 12'd4);
                2: apply_settings(8'd255, 8'd255, 12'd4095, 12'd4095, 12'd4095);
                3: apply_settings(8'd0, 8'd0, 12'd0, 12'd0, 12'd0);
                default: apply_settings(8'($urandom_range(0, 12)), 8'($urandom_range(0, 8)),
                                        12'($urandom_range(0, 24)),
                                        12'($urandom_range(0, 24)),
                                        12'($urandom_range(0, 20)));
            endcase
            queue_random_ticks((b == 2) ? 200 : 85);
            wait_drained();
        end

        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("[fpga_serial_config_sequencer] OK");
        end else begin
            $display("[fpga_serial_config_sequencer] ERROR");
        end
        $finish;
    end

endmodule
